FILE: rtl/clnw_pkg.sv
// Shared types and constants for the character LCD number writer.
// Holds the request and bus-write word layouts, request codes and the init table.
// No dependencies.
`default_nettype none

package clnw_pkg;

	localparam int VALUE_W = 16;
	localparam int CNT_W   = 4;

	typedef enum logic [1:0] {
		FUNC_NUMBER = 2'd0,
		FUNC_CHAR   = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_INIT   = 2'd3
	} func_t;

	typedef struct packed {
		func_t               func;
		logic [1:0]          row;
		logic [5:0]          column;
		logic [VALUE_W-1:0]  value;
		logic [4:0]          digit_count;
		logic [7:0]          character;
	} req_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
		logic       last;
	} wr_t;

	localparam logic [1:0] ROW_TOP    = 2'd1;
	localparam logic [1:0] ROW_BOTTOM = 2'd2;

	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [1:0] INIT_LAST  = 2'd3;

	localparam logic [7:0] INIT_SEQ [4] = '{8'h38, 8'h0C, 8'h06, 8'h01};

endpackage

`default_nettype wire

FILE: rtl/char_lcd_number_writer_unit.sv
// Character LCD number writer: top level, turns requests into controller bus writes.
// Depends on clnw_pkg for the request and write word types and constants.
//
// Usage: a request word is taken on req when req_valid and req_ready are high at a
// clock edge; req_ready is high only while the sequencer is idle. Each request
// yields a run of bus-write words on wr (valid/ready), the final one marked last.
// A show-number request first runs a shift-and-add-3 binary to BCD conversion,
// one value bit per cycle, then emits one write per cycle while wr_ready is high:
// cursor, leading '0' pads, then digits. Other requests emit at once. A number
// request thus yields one cursor write plus one per digit place; a character request
// 2 writes, clear 1, init 4. Number or character requests with a bad position, and
// number requests with a zero digit count, produce no write; the block stays ready.
// The last write sits in an output register, so the next request is taken while
// it waits. If the receiver stalls, the output register holds its word and the
// sequencer waits. Reset empties the output register and returns to idle.
`default_nettype none

module char_lcd_number_writer_unit #(
	parameter int MAX_DIGITS  = 16,
	parameter int REAL_DIGITS = 5,
	parameter int MAX_COLUMN  = 40
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire clnw_pkg::req_t req,
	output logic               wr_valid,
	input  wire logic          wr_ready,
	output clnw_pkg::wr_t      wr
);
	import clnw_pkg::*;

	localparam int PAD_W = $clog2(MAX_DIGITS + 1);
	localparam int DIG_W = $clog2(REAL_DIGITS + 1);
	localparam int BCD_W = 4 * REAL_DIGITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t              state_q;
	func_t               func_q;
	logic                cursor_q;
	logic [7:0]          cursor_byte_q;
	logic [PAD_W-1:0]    pad_q;
	logic [DIG_W-1:0]    dig_q;
	logic [7:0]          char_q;
	logic [1:0]          init_idx_q;
	logic [VALUE_W-1:0]  shift_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [CNT_W-1:0]    bit_cnt_q;
	logic                wr_valid_q;
	wr_t                 wr_q;

	logic                pos_ok;
	logic [5:0]          len_c;
	logic                len_over;
	logic [BCD_W-1:0]    bcd_adj;
	logic [DIG_W-1:0]    dig_sel;
	logic [3:0]          digit;
	logic                load;
	wr_t                 next_wr;

	assign req_ready = (state_q == ST_IDLE);
	assign wr_valid  = wr_valid_q;
	assign wr        = wr_q;

	assign pos_ok = (req.row == ROW_TOP || req.row == ROW_BOTTOM) && (req.column != 6'd0)
		&& ({1'b0, req.column} <= 7'(MAX_COLUMN));
	assign len_c    = ({1'b0, req.digit_count} > 6'(MAX_DIGITS)) ? 6'(MAX_DIGITS)
		: {1'b0, req.digit_count};
	assign len_over = len_c > 6'(REAL_DIGITS);

	always_comb begin
		for (int d = 0; d < REAL_DIGITS; d++) begin
			bcd_adj[d*4 +: 4] = (bcd_q[d*4 +: 4] >= 4'd5) ? bcd_q[d*4 +: 4] + 4'd3
				: bcd_q[d*4 +: 4];
		end
	end

	assign dig_sel = dig_q - 1'b1;
	assign digit   = bcd_q[{dig_sel, 2'b00} +: 4];
	assign load    = (state_q == ST_EMIT) && (!wr_valid_q || wr_ready);

	always_comb begin
		next_wr = '{is_data: 1'b0, bus_byte: cursor_byte_q, last: 1'b0};
		if (!cursor_q) begin
			unique case (func_q)
				FUNC_NUMBER: begin
					if (pad_q != '0) begin
						next_wr = '{is_data: 1'b1, bus_byte: ASCII_ZERO, last: 1'b0};
					end else begin
						next_wr = '{is_data: 1'b1, bus_byte: ASCII_ZERO | {4'd0, digit},
							last: (dig_q == DIG_W'(1))};
					end
				end
				FUNC_CHAR:  next_wr = '{is_data: 1'b1, bus_byte: char_q, last: 1'b1};
				FUNC_CLEAR: next_wr = '{is_data: 1'b0, bus_byte: CMD_CLEAR, last: 1'b1};
				FUNC_INIT: begin
					next_wr = '{is_data: 1'b0, bus_byte: INIT_SEQ[init_idx_q],
						last: (init_idx_q == INIT_LAST)};
				end
				default: next_wr = '{is_data: 1'b0, bus_byte: CMD_CLEAR, last: 1'b1};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			func_q        <= FUNC_NUMBER;
			cursor_q      <= 1'b0;
			cursor_byte_q <= '0;
			pad_q         <= '0;
			dig_q         <= '0;
			char_q        <= '0;
			init_idx_q    <= '0;
			shift_q       <= '0;
			bcd_q         <= '0;
			bit_cnt_q     <= '0;
			wr_valid_q    <= 1'b0;
			wr_q          <= '0;
		end else begin
			if (load) begin
				wr_valid_q <= 1'b1;
				wr_q       <= next_wr;
			end else if (wr_ready) begin
				wr_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						func_q        <= req.func;
						char_q        <= req.character;
						init_idx_q    <= '0;
						cursor_byte_q <= {1'b1, (req.row == ROW_BOTTOM), req.column - 6'd1};
						shift_q       <= req.value;
						bcd_q         <= '0;
						bit_cnt_q     <= '0;
						pad_q         <= len_over ? PAD_W'(len_c - 6'(REAL_DIGITS)) : '0;
						dig_q         <= len_over ? DIG_W'(REAL_DIGITS) : DIG_W'(len_c);
						unique case (req.func)
							FUNC_NUMBER: begin
								cursor_q <= 1'b1;
								if (pos_ok && len_c != 6'd0) begin
									state_q <= ST_CONV;
								end
							end
							FUNC_CHAR: begin
								cursor_q <= 1'b1;
								if (pos_ok) begin
									state_q <= ST_EMIT;
								end
							end
							default: begin
								cursor_q <= 1'b0;
								state_q  <= ST_EMIT;
							end
						endcase
					end
				end
				ST_CONV: begin
					bcd_q     <= {bcd_adj[BCD_W-2:0], shift_q[VALUE_W-1]};
					shift_q   <= {shift_q[VALUE_W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == CNT_W'(VALUE_W - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (cursor_q) begin
							cursor_q <= 1'b0;
						end else if (func_q == FUNC_NUMBER) begin
							if (pad_q != '0) begin
								pad_q <= pad_q - 1'b1;
							end else begin
								dig_q <= dig_q - 1'b1;
							end
						end else if (func_q == FUNC_INIT) begin
							init_idx_q <= init_idx_q + 1'b1;
						end
						if (next_wr.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: bench/char_lcd_number_writer_unit_test.sv
// Testbench for char_lcd_number_writer_unit: random and directed requests against a
// scoreboard that expands each request into its expected controller bus writes.
// Depends on clnw_pkg and the char_lcd_number_writer_unit RTL.
`timescale 1ns / 1ps

module char_lcd_number_writer_unit_test;
	import clnw_pkg::*;

	localparam int MAX_DIGITS   = 16;
	localparam int REAL_DIGITS  = 5;
	localparam int MAX_COLUMN   = 40;
	localparam int RANDOM_WORDS = 380;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 40;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int REPORT_MAX   = 10;

	localparam logic [7:0] CURSOR_CMD = 8'h80;
	localparam logic [7:0] ROW2_BASE  = 8'h40;
	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [7:0] CLEAR_CMD  = 8'h01;
	localparam logic [7:0] INIT_BYTES [4] = '{8'h38, 8'h0C, 8'h06, 8'h01};

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic DATA_WRITE = 1'b1;

	class lcd_write_scoreboard;
		wr_t expected_writes[$];
		int  mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void push_write(logic is_data, logic [7:0] bus_byte);
			wr_t w;
			w.is_data  = is_data;
			w.bus_byte = bus_byte;
			w.last     = 1'b0;
			expected_writes.push_back(w);
		endfunction

		// Expand one accepted request into its bus writes; return how many.
		function int note_request(req_t r);
			int          start;
			int          n;
			int          i;
			int unsigned scale;
			bit          placed;
			logic [7:0]  addr;
			wr_t         tail;
			start  = expected_writes.size();
			placed = (r.row == ROW_TOP || r.row == ROW_BOTTOM) &&
				r.column >= 1 && r.column <= MAX_COLUMN;
			addr   = (r.row == ROW_TOP) ? 8'(r.column) - 8'd1 : ROW2_BASE + 8'(r.column) - 8'd1;
			case (r.func)
				FUNC_NUMBER: begin
					if (placed && r.digit_count != 0) begin
						push_write(CMD_WRITE, CURSOR_CMD | addr);
						n = (r.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(r.digit_count);
						while (n > REAL_DIGITS) begin
							push_write(DATA_WRITE, DIGIT_BASE);
							n--;
						end
						for (i = n - 1; i >= 0; i--) begin
							scale = 1;
							repeat (i) scale *= 10;
							push_write(DATA_WRITE, DIGIT_BASE | 8'((r.value / scale) % 10));
						end
					end
				end
				FUNC_CHAR: begin
					if (placed) begin
						push_write(CMD_WRITE, CURSOR_CMD | addr);
						push_write(DATA_WRITE, r.character);
					end
				end
				FUNC_CLEAR: push_write(CMD_WRITE, CLEAR_CMD);
				default: begin
					for (i = 0; i < 4; i++) push_write(CMD_WRITE, INIT_BYTES[i]);
				end
			endcase
			if (expected_writes.size() > start) begin
				tail = expected_writes.pop_back();
				tail.last = 1'b1;
				expected_writes.push_back(tail);
			end
			return expected_writes.size() - start;
		endfunction

		function void check_write(wr_t got);
			wr_t want;
			if (expected_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected write: is_data=%0b byte=%02h last=%0b",
						got.is_data, got.bus_byte, got.last);
				return;
			end
			want = expected_writes.pop_front();
			if (got.is_data !== want.is_data || got.bus_byte !== want.bus_byte ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("write mismatch: expected is_data=%0b byte=%02h last=%0b, got is_data=%0b byte=%02h last=%0b",
						want.is_data, want.bus_byte, want.last,
						got.is_data, got.bus_byte, got.last);
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic wr_valid;
	logic wr_ready  = 1'b0;
	wr_t  wr;

	lcd_write_scoreboard board = new();
	int   words_sent   = 0;
	int   words_placed = 0;
	int   writes_taken = 0;
	int   cycles       = 0;

	char_lcd_number_writer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr        (wr)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic req_t make_request(func_t f, logic [1:0] row, logic [5:0] column,
			logic [15:0] value, logic [4:0] digit_count, logic [7:0] character);
		req_t r;
		r.func        = f;
		r.row         = row;
		r.column      = column;
		r.value       = value;
		r.digit_count = digit_count;
		r.character   = character;
		return r;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   pick;
		r = req_t'({$urandom, $urandom});
		pick = $urandom_range(0, 3);
		if (pick == 0) r.value = 16'hFFFF;
		else if (pick == 1) r.value = 16'($urandom_range(0, 999));
		// keep most words well formed, the rest are raw noise
		if ($urandom_range(0, 99) < 85) begin
			r.row    = 2'($urandom_range(1, 2));
			r.column = 6'($urandom_range(1, MAX_COLUMN));
			pick     = $urandom_range(0, 99);
			if (pick < 55) r.func = FUNC_NUMBER;
			else if (pick < 80) r.func = FUNC_CHAR;
			else if (pick < 90) r.func = FUNC_CLEAR;
			else r.func = FUNC_INIT;
			pick = $urandom_range(0, 99);
			if (pick < 70) r.digit_count = 5'($urandom_range(1, 6));
			else if (pick < 95) r.digit_count = 5'($urandom_range(7, MAX_DIGITS));
			else r.digit_count = 5'($urandom_range(MAX_DIGITS + 1, 31));
		end
		return r;
	endfunction

	function automatic int pick_gap(int idx, int quiet_phase);
		if ((idx / 40) % 4 == quiet_phase) return 0;
		return $urandom_range(0, 19);
	endfunction

	// Enter and leave at a falling edge; valid stays high when no gap follows.
	task automatic send_word(req_t w);
		int gap;
		gap = pick_gap(words_sent, 3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (board.note_request(w) > 0) words_placed++;
		words_sent++;
		@(negedge clk);
	endtask

	initial begin
		req_t directed [$];
		directed.push_back(make_request(FUNC_INIT,   2'd0, 6'd0,  16'h0000, 5'd0,  8'h00));
		directed.push_back(make_request(FUNC_CLEAR,  2'd3, 6'd63, 16'hFFFF, 5'd31, 8'hFF));
		directed.push_back(make_request(FUNC_NUMBER, 2'd1, 6'd1,  16'd0,    5'd1,  8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd2, 6'd40, 16'hFFFF, 5'd5,  8'hFF));
		directed.push_back(make_request(FUNC_NUMBER, 2'd1, 6'd40, 16'hFFFF, 5'd16, 8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd2, 6'd1,  16'd12345, 5'd31, 8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd2, 6'd20, 16'd54321, 5'd17, 8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd1, 6'd7,  16'd65535, 5'd6,  8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd1, 6'd9,  16'd54321, 5'd3,  8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd1, 6'd5,  16'd99,    5'd0,  8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd0, 6'd5,  16'd99,    5'd2,  8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd3, 6'd5,  16'd99,    5'd2,  8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd1, 6'd0,  16'd99,    5'd2,  8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd2, 6'd41, 16'd99,    5'd2,  8'h00));
		directed.push_back(make_request(FUNC_NUMBER, 2'd2, 6'd63, 16'd99,    5'd2,  8'h00));
		directed.push_back(make_request(FUNC_CHAR,   2'd1, 6'd1,  16'h0000, 5'd0,  8'h00));
		directed.push_back(make_request(FUNC_CHAR,   2'd2, 6'd40, 16'hFFFF, 5'd31, 8'hFF));
		directed.push_back(make_request(FUNC_CHAR,   2'd3, 6'd10, 16'd0,    5'd0,  8'h41));
		directed.push_back(make_request(FUNC_CHAR,   2'd1, 6'd0,  16'd0,    5'd0,  8'h41));
		directed.push_back(make_request(FUNC_CHAR,   2'd2, 6'd41, 16'd0,    5'd0,  8'h41));
		directed.push_back(make_request(FUNC_INIT,   2'd3, 6'd63, 16'hFFFF, 5'd31, 8'hFF));
		directed.push_back(make_request(FUNC_CLEAR,  2'd0, 6'd0,  16'h0000, 5'd0,  8'h00));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[k]) send_word(directed[k]);
		words_placed = 0;
		while (words_placed < RANDOM_WORDS) send_word(random_request());
		req_valid <= 1'b0;
		while (board.expected_writes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		int  stall;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pick_gap(writes_taken, 2);
			// hold off long once so the block backs up into its input
			if (!held && writes_taken >= HOLD_AFTER) begin
				stall = HOLD_CYCLES;
				held  = 1'b1;
			end
			if (stall > 0) begin
				wr_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			wr_ready <= 1'b1;
			do @(posedge clk); while (!wr_valid);
			board.check_write(wr);
			writes_taken++;
			@(negedge clk);
		end
	end

endmodule

FILE: sim.f
rtl/clnw_pkg.sv
rtl/char_lcd_number_writer_unit.sv
bench/char_lcd_number_writer_unit_test.sv
